FILE: rtl/core/csqrt_pkg.sv
// Package for the complex square root block: default sizes.
// No dependencies.
`timescale 1ns / 1ps
package csqrt_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
endpackage

FILE: rtl/core/csqrt_sqrt_cell.sv
// One restoring square-root cell: settles one root bit per stage and passes its word on.
// Depends on nothing; used in a chain by csqrt_sqrt_chain.
`timescale 1ns / 1ps
module csqrt_sqrt_cell #(
   parameter int RW = 32,
   parameter int RB = 0,
   parameter int SW = 64,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          valid_in,
   input  logic          enable,
   input  logic [SW-1:0] rad_in,
   input  logic [RW-1:0] root_in,
   input  logic [PW-1:0] pass_in,
   output logic          valid_out,
   output logic [SW-1:0] rad_out,
   output logic [RW-1:0] root_out,
   output logic [PW-1:0] pass_out
);
   logic [RW-1:0] cand;
   logic [2*RW-1:0] sq;
   logic take;
   logic valid_ff;
   logic [SW-1:0] rad_ff;
   logic [RW-1:0] root_ff, root_in_v;
   logic [PW-1:0] pass_ff;

   always_comb begin
      cand = root_in | (RW'(1) << RB);
      sq   = {{RW{1'b0}}, cand} * {{RW{1'b0}}, cand};
      if (2 * RW >= SW) begin
         take = sq <= (2*RW)'(rad_in);
      end else begin
         take = SW'(sq) <= rad_in;
      end
      root_in_v = take ? cand : root_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         rad_ff  <= rad_in;
         root_ff <= root_in_v;
         pass_ff <= pass_in;
      end
   end

   assign valid_out = valid_ff;
   assign rad_out   = rad_ff;
   assign root_out  = root_ff;
   assign pass_out  = pass_ff;
endmodule

FILE: rtl/core/csqrt_div_cell.sv
// One restoring division cell: shifts in one dividend bit and settles one quotient bit.
// Depends on nothing; used in a chain by csqrt_div_chain.
`timescale 1ns / 1ps
module csqrt_div_cell #(
   parameter int NW = 64,
   parameter int DW = 33,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          valid_in,
   input  logic          enable,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   input  logic [DW:0]   rem_in,
   input  logic [NW-1:0] quo_in,
   input  logic [PW-1:0] pass_in,
   output logic          valid_out,
   output logic [NW-1:0] num_out,
   output logic [DW-1:0] den_out,
   output logic [DW:0]   rem_out,
   output logic [NW-1:0] quo_out,
   output logic [PW-1:0] pass_out
);
   logic [DW+1:0] shifted;
   logic ge;
   logic valid_ff;
   logic [NW-1:0] num_ff, quo_ff;
   logic [DW-1:0] den_ff;
   logic [DW:0] rem_ff, rem_in_v;
   logic [PW-1:0] pass_ff;

   always_comb begin
      shifted  = {rem_in, num_in[NW-1]};
      ge       = shifted >= {2'b00, den_in};
      rem_in_v = ge ? (DW+1)'(shifted - {2'b00, den_in}) : (DW+1)'(shifted);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         num_ff  <= {num_in[NW-2:0], 1'b0};
         den_ff  <= den_in;
         rem_ff  <= rem_in_v;
         quo_ff  <= {quo_in[NW-2:0], ge};
         pass_ff <= pass_in;
      end
   end

   assign valid_out = valid_ff;
   assign num_out   = num_ff;
   assign den_out   = den_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;
   assign pass_out  = pass_ff;
endmodule

FILE: rtl/core/csqrt_sqrt_chain.sv
// Row of square-root cells, most significant root bit first.
// Depends on csqrt_sqrt_cell.
`timescale 1ns / 1ps
module csqrt_sqrt_chain #(
   parameter int RW = 32,
   parameter int SW = 64,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          valid_in,
   input  logic [SW-1:0] rad_in,
   input  logic [PW-1:0] pass_in,
   output logic          valid_out,
   output logic [RW-1:0] root_out,
   output logic [PW-1:0] pass_out
);
   logic          v [0:RW];
   logic [SW-1:0] r [0:RW];
   logic [RW-1:0] q [0:RW];
   logic [PW-1:0] p [0:RW];

   assign v[0] = valid_in;
   assign r[0] = rad_in;
   assign q[0] = '0;
   assign p[0] = pass_in;

   for (genvar i = 0; i < RW; i++) begin : g_cell
      csqrt_sqrt_cell #(.RW(RW), .RB(RW - 1 - i), .SW(SW), .PW(PW)) u_cell (
         .clock(clock), .reset(reset), .valid_in(v[i]), .enable(enable),
         .rad_in(r[i]), .root_in(q[i]), .pass_in(p[i]),
         .valid_out(v[i+1]), .rad_out(r[i+1]), .root_out(q[i+1]), .pass_out(p[i+1])
      );
   end

   assign valid_out = v[RW];
   assign root_out  = q[RW];
   assign pass_out  = p[RW];
endmodule

FILE: rtl/core/csqrt_div_chain.sv
// Row of division cells giving the full-width quotient of num by den.
// Depends on csqrt_div_cell.
`timescale 1ns / 1ps
module csqrt_div_chain #(
   parameter int NW = 64,
   parameter int DW = 33,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          valid_in,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   input  logic [PW-1:0] pass_in,
   output logic          valid_out,
   output logic [NW-1:0] quo_out,
   output logic [PW-1:0] pass_out
);
   logic          v [0:NW];
   logic [NW-1:0] n [0:NW];
   logic [DW-1:0] d [0:NW];
   logic [DW:0]   r [0:NW];
   logic [NW-1:0] q [0:NW];
   logic [PW-1:0] p [0:NW];

   assign v[0] = valid_in;
   assign n[0] = num_in;
   assign d[0] = den_in;
   assign r[0] = '0;
   assign q[0] = '0;
   assign p[0] = pass_in;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      csqrt_div_cell #(.NW(NW), .DW(DW), .PW(PW)) u_cell (
         .clock(clock), .reset(reset), .valid_in(v[i]), .enable(enable),
         .num_in(n[i]), .den_in(d[i]), .rem_in(r[i]), .quo_in(q[i]), .pass_in(p[i]),
         .valid_out(v[i+1]), .num_out(n[i+1]), .den_out(d[i+1]), .rem_out(r[i+1]),
         .quo_out(q[i+1]), .pass_out(p[i+1])
      );
   end

   assign valid_out = v[NW];
   assign quo_out   = q[NW];
   assign pass_out  = p[NW];
endmodule

FILE: rtl/core/complex_square_root.sv
// Principal square root of a complex word in signed fixed point. It takes one word
// every cycle while not stalled. A word passes through the magnitude root chain, the
// main root chain and the divider chain, one cell per result bit, and then through
// the output register. A stall freezes the whole pipeline.
// Depends on csqrt_pkg, csqrt_sqrt_chain and csqrt_div_chain.
`timescale 1ns / 1ps
module complex_square_root #(
   parameter int DATA_WIDTH = csqrt_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = csqrt_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_real_in,
   input  logic signed [DATA_WIDTH-1:0] req_imag_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_real_out,
   output logic signed [DATA_WIDTH-1:0] rsp_imag_out
);
   localparam int W   = DATA_WIDTH;
   localparam int SW  = 2 * W + 1;
   localparam int MW  = W + 1;
   localparam int TW  = W + 2 + FRAC_BITS;
   localparam int RW  = (TW + 1) / 2;
   localparam int NW  = W + 1 + FRAC_BITS;
   localparam int DW  = W + 1;
   localparam int P1  = 2 + W;
   localparam int P2  = 2 + W + 1 + W + 1;
   localparam int P3  = 4;
   localparam logic [W-1:0] LIMIT = {1'b0, {(W-1){1'b1}}};

   logic enable;
   logic [W:0] ax, ay;
   logic [2*W+1:0] sum;
   logic [W:0] mag;
   logic m_valid;
   logic [P1-1:0] m_pass;
   logic [MW-1:0] m_ax, m_ay;
   logic [TW-1:0] t_rad;
   logic r_valid;
   logic [RW-1:0] root;
   logic [P2-1:0] r_pass;
   logic [W-1:0] root_sat;
   logic [NW-1:0] num;
   logic d_valid;
   logic [NW-1:0] quo;
   logic [P3-1:0] d_pass;
   logic [W-1:0] part, main_v, part_v;
   logic nx, ny;
   logic out_valid_ff;
   logic [W-1:0] real_ff, imag_ff, real_in_v, imag_in_v;

   assign enable    = !(out_valid_ff && rsp_stall);
   assign req_stall = !enable;

   always_comb begin
      ax  = req_real_in[W-1] ? (W+1)'(-{req_real_in[W-1], req_real_in})
                             : (W+1)'({1'b0, req_real_in});
      ay  = req_imag_in[W-1] ? (W+1)'(-{req_imag_in[W-1], req_imag_in})
                             : (W+1)'({1'b0, req_imag_in});
      sum = (2*W+2)'(ax * ax) + (2*W+2)'(ay * ay);
   end

   csqrt_sqrt_chain #(.RW(W + 1), .SW(SW), .PW(P1)) u_mag (
      .clock(clock), .reset(reset), .enable(enable), .valid_in(req_valid),
      .rad_in(SW'(sum)), .pass_in({req_real_in[W-1], req_imag_in[W-1], ax[W-1:0]}),
      .valid_out(m_valid), .root_out(mag), .pass_out(m_pass)
   );

   always_comb begin
      m_ax  = {(m_pass[W-1:0] == '0) && m_pass[W+1], m_pass[W-1:0]};
      m_ay  = '0;
      t_rad = TW'((MW+1)'(mag) + (MW+1)'(m_ax)) << (FRAC_BITS - 1);
   end

   logic [W-1:0] ay_d;
   logic [W-1:0] ay_pipe [0:W];
   assign ay_pipe[0] = ay[W-1:0];
   for (genvar i = 0; i < W + 1; i++) begin : g_ay
      logic [W-1:0] ay_ff;
      always_ff @(posedge clock) begin
         if (enable) begin
            ay_ff <= ay_pipe[i];
         end
      end
      if (i < W) begin : g_link
         assign ay_pipe[i+1] = ay_ff;
      end else begin : g_last
         assign ay_d = ay_ff;
      end
   end

   csqrt_sqrt_chain #(.RW(RW), .SW(TW), .PW(P2)) u_root (
      .clock(clock), .reset(reset), .enable(enable), .valid_in(m_valid),
      .rad_in(t_rad),
      .pass_in({m_pass[W+1], m_pass[W], m_ax, (mag == '0), ay_d}),
      .valid_out(r_valid), .root_out(root), .pass_out(r_pass)
   );

   always_comb begin
      root_sat = (RW > W - 1 && (root >> (W - 1)) != '0) ? LIMIT : W'(root);
      num      = NW'(r_pass[W-1:0]) << FRAC_BITS;
   end

   csqrt_div_chain #(.NW(NW), .DW(DW), .PW(P3)) u_div (
      .clock(clock), .reset(reset), .enable(enable), .valid_in(r_valid),
      .num_in(num), .den_in({root_sat, 1'b0}),
      .pass_in({r_pass[P2-1], r_pass[P2-2], (r_pass[P2-3 -: MW] != '0) && !r_pass[P2-1],
                r_pass[W]}),
      .valid_out(d_valid), .quo_out(quo), .pass_out(d_pass)
   );

   logic [W-1:0] rs_pipe [0:NW];
   assign rs_pipe[0] = root_sat;
   for (genvar i = 0; i < NW; i++) begin : g_rs
      logic [W-1:0] rs_ff;
      always_ff @(posedge clock) begin
         if (enable) begin
            rs_ff <= rs_pipe[i];
         end
      end
      assign rs_pipe[i+1] = rs_ff;
   end

   always_comb begin
      nx     = !d_pass[1];
      ny     = d_pass[2];
      part   = ((quo >> (W - 1)) != '0) ? LIMIT : W'(quo);
      if (rs_pipe[NW] == '0) begin
         part = '0;
      end
      if (d_pass[1]) begin
         main_v    = rs_pipe[NW];
         part_v    = ny ? W'(-part) : part;
         real_in_v = main_v;
         imag_in_v = part_v;
      end else begin
         main_v    = ny ? W'(-rs_pipe[NW]) : rs_pipe[NW];
         part_v    = part;
         real_in_v = part_v;
         imag_in_v = main_v;
      end
      if (d_pass[0]) begin
         real_in_v = '0;
         imag_in_v = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= d_valid;
      end
      if (enable) begin
         real_ff <= real_in_v;
         imag_ff <= imag_in_v;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_real_out = real_ff;
   assign rsp_imag_out = imag_ff;

   logic unused_ok;
   assign unused_ok = ^{m_ay, nx};
endmodule
